@@ src/modinv_pkg.sv @@
// Shared types and constants for the modular inverse and gcd unit.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
package modinv_pkg;

  // Width of every numeric field on the ports.
  localparam int unsigned DATA_BITS = 63;

  // Default operand width inside the datapath.
  localparam int unsigned OPERAND_BITS_DEFAULT = 63;

  typedef struct packed {
    logic [DATA_BITS-1:0] value;
    logic [DATA_BITS-1:0] modulus;
  } modinv_in_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] divisor;
    logic [DATA_BITS-1:0] inverse;
    logic                 found;
  } modinv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_REDUCE,
    ST_FIX,
    ST_FINISH
  } modinv_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ALIGN,
    OP_REDUCE,
    OP_FIX,
    OP_FINISH
  } modinv_op_e;

  typedef struct packed {
    modinv_op_e op;
  } modinv_cmd_t;

  typedef struct packed {
    logic rem_zero;   // current divisor of the Euclid step is zero
    logic can_align;  // doubling the shifted divisor keeps it no larger than the dividend
    logic last_bit;   // the quotient bit being worked on is the lowest one
    logic out_free;   // the output register can take a result this cycle
  } modinv_status_t;

endpackage

@@ src/modinv_dp.sv @@
// Datapath of the modular inverse and gcd unit: Euclid remainders, coefficients and output register.
// Depends on modinv_pkg; driven by modinv_ctrl through a command struct.
module modinv_dp #(
  parameter int unsigned OPERAND_BITS = modinv_pkg::OPERAND_BITS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  modinv_pkg::modinv_in_t in_data_i,
  input  logic                   out_stall_i,
  input  modinv_pkg::modinv_cmd_t cmd_i,
  output modinv_pkg::modinv_status_t status_o,
  output logic                   out_valid_o,
  output modinv_pkg::modinv_out_t out_data_o
);

  localparam int unsigned W    = OPERAND_BITS;
  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    r0_q, r0_d, r1_q, r1_d, mod_q, mod_d;
  logic [W-1:0]    t0_q, t0_d, t1_q, t1_d;
  logic [W-1:0]    div_q, div_d, tdiv_q, tdiv_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            neg_q, neg_d;
  logic            out_valid_q, out_valid_d;
  modinv_pkg::modinv_out_t out_q, out_d;

  logic            sub_ok;
  logic [W-1:0]    r0_sub, t0_add;
  logic            found;
  logic [W-1:0]    inv_mag;

  // One trial subtraction of the shifted divisor per cycle.
  assign sub_ok = (r0_q >= div_q);
  assign r0_sub = sub_ok ? (r0_q - div_q) : r0_q;
  assign t0_add = sub_ok ? (t0_q + tdiv_q) : t0_q;

  assign found   = (|mod_q[W-1:1]) && (r0_q == W'(1)) && (t0_q != '0);
  assign inv_mag = neg_q ? (mod_q - t0_q) : t0_q;

  assign status_o.rem_zero  = (r1_q == '0);
  assign status_o.can_align = ({div_q, 1'b0} <= {1'b0, r0_q});
  assign status_o.last_bit  = (cnt_q == '0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    r0_d   = r0_q;
    r1_d   = r1_q;
    mod_d  = mod_q;
    t0_d   = t0_q;
    t1_d   = t1_q;
    div_d  = div_q;
    tdiv_d = tdiv_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    out_d  = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (cmd_i.op)
      modinv_pkg::OP_LOAD: begin
        // Start from (a, m) with coefficients +1 and 0 for a.
        r0_d   = in_data_i.value[W-1:0];
        r1_d   = in_data_i.modulus[W-1:0];
        mod_d  = in_data_i.modulus[W-1:0];
        t0_d   = W'(1);
        t1_d   = '0;
        div_d  = in_data_i.modulus[W-1:0];
        tdiv_d = '0;
        cnt_d  = '0;
        neg_d  = 1'b0;
      end
      modinv_pkg::OP_ALIGN: begin
        div_d  = {div_q[W-2:0], 1'b0};
        tdiv_d = {tdiv_q[W-2:0], 1'b0};
        cnt_d  = cnt_q + CntW'(1);
      end
      modinv_pkg::OP_REDUCE: begin
        if (cnt_q == '0) begin
          // Quotient complete: rotate the remainder pair and prepare the next divisor.
          r0_d   = r1_q;
          r1_d   = r0_sub;
          t0_d   = t1_q;
          t1_d   = t0_add;
          div_d  = r0_sub;
          tdiv_d = t0_add;
          neg_d  = !neg_q;
        end else begin
          r0_d   = r0_sub;
          t0_d   = t0_add;
          div_d  = {1'b0, div_q[W-1:1]};
          tdiv_d = {1'b0, tdiv_q[W-1:1]};
          cnt_d  = cnt_q - CntW'(1);
        end
      end
      modinv_pkg::OP_FIX: begin
        if (t0_q >= mod_q) begin
          t0_d = t0_q - mod_q;
        end
      end
      modinv_pkg::OP_FINISH: begin
        out_d.divisor = modinv_pkg::DATA_BITS'(r0_q);
        out_d.found   = found;
        out_d.inverse = found ? modinv_pkg::DATA_BITS'(inv_mag) : '0;
        out_valid_d   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    mod_q  <= mod_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    div_q  <= div_d;
    tdiv_q <= tdiv_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/modinv_ctrl.sv @@
// Controller of the modular inverse and gcd unit: sequences load, division steps and result.
// Depends on modinv_pkg; commands modinv_dp through a command struct.
module modinv_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  modinv_pkg::modinv_status_t status_i,
  output modinv_pkg::modinv_cmd_t    cmd_o
);

  modinv_pkg::modinv_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modinv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = modinv_pkg::OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      modinv_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = modinv_pkg::OP_LOAD;
          state_d  = modinv_pkg::ST_ALIGN;
        end
      end
      modinv_pkg::ST_ALIGN: begin
        if (status_i.rem_zero) begin
          state_d = modinv_pkg::ST_FIX;
        end else if (status_i.can_align) begin
          cmd_o.op = modinv_pkg::OP_ALIGN;
        end else begin
          state_d = modinv_pkg::ST_REDUCE;
        end
      end
      modinv_pkg::ST_REDUCE: begin
        cmd_o.op = modinv_pkg::OP_REDUCE;
        if (status_i.last_bit) begin
          state_d = modinv_pkg::ST_ALIGN;
        end
      end
      modinv_pkg::ST_FIX: begin
        cmd_o.op = modinv_pkg::OP_FIX;
        state_d  = modinv_pkg::ST_FINISH;
      end
      modinv_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.op = modinv_pkg::OP_FINISH;
          state_d  = modinv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = modinv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/modular_inverse_and_gcd_unit.sv @@
// Modular inverse and gcd unit: one result per input transfer, computed by shift-subtract Euclid.
// Each Euclid step doubles the divisor into place and then subtracts it back down, one quotient
// bit per reduce step; a fix step and a finish step then end the item.
// One item is worked on at a time; the next input transfer is taken once the result is registered,
// even while that result still waits on a stalled output.
// Reset (rst_ni, asynchronous, active low) returns the controller to idle and empties the output.
module modular_inverse_and_gcd_unit #(
  parameter int unsigned OPERAND_BITS = modinv_pkg::OPERAND_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  modinv_pkg::modinv_in_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output modinv_pkg::modinv_out_t out_data_o
);

  // The controller and datapath talk only through these two structs. The datapath keeps the
  // remainder pair (r0, r1) and the magnitudes of the coefficients of the value, whose signs
  // alternate. Each quotient is found by first doubling the divisor until it would pass the
  // dividend, then subtracting it back down one bit per cycle; the last subtraction also
  // rotates the pair for the next Euclid step.
  modinv_pkg::modinv_cmd_t    cmd;
  modinv_pkg::modinv_status_t status;

  modinv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // When the remainder reaches zero, r0 holds the gcd. The coefficient is then brought below the
  // modulus and, if the gcd is one and the modulus at least two, negated as its sign requires.
  modinv_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/modinv_checker.sv @@
// Port-level checker for the modular inverse and gcd unit, bound to the top level.
// Depends on modinv_pkg and modular_inverse_and_gcd_unit.
module modinv_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input modinv_pkg::modinv_out_t out_data_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or was dropped");

  // The unit works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is still at work");

  // An inverse exists only when the gcd is one, and it is never zero.
  a_found_gcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.found |-> out_data_o.divisor == 1 && out_data_o.inverse != 0)
    else $error("inverse reported with gcd not one or zero inverse");

  // Without an inverse the field reads zero.
  a_no_inverse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.inverse == 0)
    else $error("nonzero inverse without found");

endmodule

bind modular_inverse_and_gcd_unit modinv_checker u_modinv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ dv/tb_modular_inverse_and_gcd_unit.sv @@
// Self-checking testbench for modular_inverse_and_gcd_unit: predicts gcd, inverse and found flag
// for every accepted pair and compares each output transfer in order. Depends on modinv_pkg.
module tb_modular_inverse_and_gcd_unit;
  import modinv_pkg::*;

  localparam logic [DATA_BITS-1:0] FIELD_MAX = '1;
  // Consecutive Fibonacci numbers give the longest Euclid chain that fits in 63 bits.
  localparam logic [DATA_BITS-1:0] FIB_91 = 63'd4660046610375530309;
  localparam logic [DATA_BITS-1:0] FIB_92 = 63'd7540113804746346429;
  // A Mersenne prime, so every non-multiple has an inverse.
  localparam logic [DATA_BITS-1:0] PRIME_M61 = 63'h1FFF_FFFF_FFFF_FFFF;
  localparam int unsigned RANDOM_PAIRS = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 3000;
  localparam int unsigned DRAIN_CYCLES = 450;

  typedef struct {
    modinv_in_t  pair;
    modinv_out_t result;
  } pending_result_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  modinv_in_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  modinv_out_t out_data;

  // Results still owed by the block, oldest first.
  pending_result_t owed_results[$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned inverses_seen = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps_on = 1'b1;
  int unsigned holdoff_request = 0;

  always #5 clk_i = ~clk_i;

  modular_inverse_and_gcd_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Expected result for one pair. The gcd comes from plain Euclid on the raw operands; the
  // inverse comes from extended Euclid on (modulus, value mod modulus), carrying the Bezout
  // coefficient of the value as a wide signed number so that no product can overflow.
  function automatic modinv_out_t predict_gcd_inverse(logic [DATA_BITS-1:0] value,
                                                      logic [DATA_BITS-1:0] modulus);
    modinv_out_t         res;
    logic [63:0]         hi;
    logic [63:0]         lo;
    logic [63:0]         rem;
    logic [63:0]         quot;
    logic signed [127:0] coef_prev;
    logic signed [127:0] coef_cur;
    logic signed [127:0] coef_next;
    res = '0;
    hi = {1'b0, value};
    lo = {1'b0, modulus};
    while (lo != 64'd0) begin
      rem = hi % lo;
      hi = lo;
      lo = rem;
    end
    res.divisor = hi[DATA_BITS-1:0];
    // Moduli of zero or one, and any shared factor, leave the inverse at zero.
    if (modulus > 63'd1 && hi == 64'd1) begin
      hi = {1'b0, modulus};
      lo = {1'b0, value} % {1'b0, modulus};
      coef_prev = '0;
      coef_cur = 128'sd1;
      while (lo != 64'd0) begin
        quot = hi / lo;
        rem = hi - quot * lo;
        coef_next = coef_prev - $signed({64'd0, quot}) * coef_cur;
        hi = lo;
        lo = rem;
        coef_prev = coef_cur;
        coef_cur = coef_next;
      end
      if (coef_prev < 0) begin
        coef_prev = coef_prev + $signed({65'd0, modulus});
      end
      res.inverse = coef_prev[DATA_BITS-1:0];
      res.found = 1'b1;
    end
    return res;
  endfunction

  // Random operand of the given bit length; short lengths keep most items quick.
  function automatic logic [DATA_BITS-1:0] random_operand(int unsigned width);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (width >= DATA_BITS) begin
      return raw[DATA_BITS-1:0];
    end
    return raw[DATA_BITS-1:0] & ((63'd1 << width) - 63'd1);
  endfunction

  function automatic int unsigned random_width();
    if ($urandom_range(0, 3) == 0) begin
      return DATA_BITS;
    end
    return $urandom_range(1, DATA_BITS);
  endfunction

  // Offers one pair and returns at the edge where the transfer happens. Between bursts of
  // random length the sender drops valid for a random gap, sometimes long enough to span a
  // whole computation, so that new items arrive in every phase of the block's work.
  task automatic send_pair(input logic [DATA_BITS-1:0] value,
                           input logic [DATA_BITS-1:0] modulus);
    modinv_in_t      item;
    pending_result_t owed;
    int unsigned     gap;
    item.value = value;
    item.modulus = modulus;
    gap = 0;
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3: gap = $urandom_range(50, 300);
        default: gap = $urandom_range(1, 12);
      endcase
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    owed.pair = item;
    owed.result = predict_gcd_inverse(value, modulus);
    owed_results.push_back(owed);
  endtask

  task automatic check_field(input string name, input modinv_in_t pair,
                             input logic [DATA_BITS-1:0] want, input logic [DATA_BITS-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s wrong for value %0d modulus %0d: expected %0d, actual %0d",
               $time, name, pair.value, pair.modulus, want, got);
    end
  endtask

  // Every output transfer is matched against the oldest owed result, field by field.
  always @(posedge clk_i) begin
    pending_result_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transfer: expected none, actual divisor %0d inverse %0d found %0b",
                 $time, out_data.divisor, out_data.inverse, out_data.found);
      end else begin
        owed = owed_results.pop_front();
        results_checked++;
        if (owed.result.found) begin
          inverses_seen++;
        end
        check_field("divisor", owed.pair, owed.result.divisor, out_data.divisor);
        check_field("inverse", owed.pair, owed.result.inverse, out_data.inverse);
        check_field("found", owed.pair, {62'd0, owed.result.found}, {62'd0, out_data.found});
      end
    end
  end

  // The receiver stalls on a rotating bit pattern that is reloaded now and then with a new
  // density, an all-clear pattern giving stretches with no stall at all. A hold-off request
  // overrides the pattern and is counted down here, cycle by cycle.
  always @(posedge clk_i) begin
    logic [31:0] stall_pattern;
    int unsigned pattern_age;
    int unsigned hold_left;
    if (holdoff_request != 0) begin
      hold_left = holdoff_request;
      holdoff_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '0;
          1: stall_pattern = $urandom;
          2: stall_pattern = $urandom & $urandom;
          default: stall_pattern = $urandom | $urandom;
        endcase
        pattern_age = $urandom_range(16, 200);
      end else begin
        pattern_age--;
      end
      out_stall <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
    end
  end

  // Zero and unit moduli, a zero value, and both zero.
  task automatic test_degenerate_moduli();
    send_pair(63'd0, 63'd0);
    send_pair(FIELD_MAX, 63'd0);
    send_pair(63'd5, 63'd1);
    send_pair(63'd0, 63'd1);
    send_pair(FIELD_MAX, 63'd1);
    send_pair(63'd0, FIELD_MAX);
    send_pair(63'd0, 63'd2);
  endtask

  // Full-width operands, the longest Euclid chain, a value above the modulus and shared factors.
  task automatic test_operand_extremes();
    send_pair(63'd1, 63'd2);
    send_pair(63'd1, FIELD_MAX);
    send_pair(FIELD_MAX - 63'd1, FIELD_MAX);
    send_pair(63'd2, FIELD_MAX);
    send_pair(FIELD_MAX, FIELD_MAX);
    send_pair(FIELD_MAX, FIELD_MAX - 63'd1);
    send_pair(FIB_91, FIB_92);
    send_pair(FIB_92, FIB_91);
    send_pair(FIELD_MAX, 63'd2);
    send_pair(63'd6, 63'd9);
    send_pair(63'h4000_0000_0000_3039, PRIME_M61);
    send_pair(PRIME_M61, PRIME_M61 + 63'd1);
    send_pair(63'h4000_0000_0000_0000, 63'h4000_0000_0000_0001);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering back to back,
  // so the result register fills, the block stops taking input and the stall reaches the sender.
  task automatic test_output_holdoff();
    holdoff_request = HOLDOFF_CYCLES;
    sender_gaps_on = 1'b0;
    repeat (10) begin
      send_pair(random_operand(DATA_BITS), random_operand(DATA_BITS));
    end
    sender_gaps_on = 1'b1;
  endtask

  // Random pairs: mostly general pairs of mixed sizes, with shared factors, values above small
  // moduli and degenerate cases mixed in.
  task automatic test_random_pairs();
    logic [DATA_BITS-1:0] value;
    logic [DATA_BITS-1:0] modulus;
    logic [DATA_BITS-1:0] factor;
    int unsigned          kind;
    int unsigned          width;
    repeat (RANDOM_PAIRS) begin
      kind = $urandom_range(0, 99);
      width = random_width();
      if (kind < 55) begin
        modulus = random_operand(width);
        value = random_operand($urandom_range(1, width));
      end else if (kind < 75) begin
        // Scaled pairs stay within the field, so the common factor survives.
        factor = DATA_BITS'($urandom_range(2, 1000));
        width = $urandom_range(1, 52);
        value = random_operand(width) * factor;
        modulus = random_operand(width) * factor;
      end else if (kind < 88) begin
        value = random_operand(DATA_BITS);
        modulus = random_operand($urandom_range(1, 20));
      end else begin
        modulus = random_operand(width);
        case ($urandom_range(0, 5))
          0: begin value = modulus; modulus = 63'd0; end
          1: begin value = modulus; modulus = 63'd1; end
          2: value = 63'd0;
          3: value = modulus;
          4: value = modulus - 63'd1;
          default: value = 63'd1;
        endcase
      end
      send_pair(value, modulus);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_degenerate_moduli();
    test_operand_extremes();
    test_output_holdoff();
    test_random_pairs();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    // Any stray transfer after the last owed result is caught by the output check meanwhile.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results, %0d with an inverse and %0d without.",
             results_checked, inverses_seen, results_checked - inverses_seen);
    $display("Covered zero and unit moduli, full-width and Fibonacci operands, shared factors, %s",
             "random stalls and one long output hold-off.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("%0t: run timed out with %0d results still owed", $time, owed_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
